/* rtl/cst_triangle_stiffness_macros.svh */
// Assertion macros shared by the triangle stiffness RTL.
`ifndef CST_TRIANGLE_STIFFNESS_MACROS_SVH
`define CST_TRIANGLE_STIFFNESS_MACROS_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/cst_pkg.sv */
// Shared types and constants of the triangle stiffness block.
package cst_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int YM_W       = 20;
    localparam int PR_W       = 15;
    localparam int TH_W       = 32;
    localparam int TE_W       = YM_W + TH_W;
    localparam int CDEN_W     = 33;
    localparam int KF_SHIFT   = 30;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    // divider sizes for the default coordinate width
    localparam int DIV_NUM_W_DEF = 168;
    localparam int DIV_DEN_W_DEF = 100;

    localparam logic [YM_W-1:0] YM_RESET = 20'd210000;
    localparam logic [PR_W-1:0] PR_RESET = 15'd19661;
    localparam logic [TH_W-1:0] TH_RESET = 32'd65536;

    localparam logic [2:0] FIRST_POS = 3'd0;
    localparam logic [2:0] LAST_POS  = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_YOUNGS  = 2'd0,
        REG_POISSON = 2'd1,
        REG_THICK   = 2'd2
    } cst_reg_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
        logic       degen;
        logic       neg;
    } cst_tag_t;

endpackage

/* rtl/cst_if.sv */
// Stream interfaces: triangle corners in, stiffness entries out.
interface cst_node_if #(
    parameter int COORD_WIDTH = cst_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] node0_x;
    logic signed [COORD_WIDTH-1:0] node0_y;
    logic signed [COORD_WIDTH-1:0] node1_x;
    logic signed [COORD_WIDTH-1:0] node1_y;
    logic signed [COORD_WIDTH-1:0] node2_x;
    logic signed [COORD_WIDTH-1:0] node2_y;

    modport source (output valid, node0_x, node0_y, node1_x, node1_y, node2_x, node2_y,
                    input ready);
    modport sink (input valid, node0_x, node0_y, node1_x, node1_y, node2_x, node2_y,
                  output ready);
endinterface

interface cst_entry_if #(
    parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    row_index;
    logic [2:0]                    col_index;
    logic signed [VALUE_WIDTH-1:0] stiffness_value;
    logic                          degenerate;
    logic                          last;

    modport source (output valid, row_index, col_index, stiffness_value, degenerate, last,
                    input ready);
    modport sink (input valid, row_index, col_index, stiffness_value, degenerate, last,
                  output ready);
endinterface

/* rtl/cst_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module cst_div #(
    parameter int NUMW        = cst_pkg::DIV_NUM_W_DEF,
    parameter int DENW        = cst_pkg::DIV_DEN_W_DEF,
    parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [NUMW-1:0]        in_num,
    input  logic [DENW-1:0]        in_den,
    input  cst_pkg::cst_tag_t      in_tag,
    output logic                   out_valid,
    output logic [VALUE_WIDTH-1:0] out_value,
    output cst_pkg::cst_tag_t      out_tag
);
    import cst_pkg::*;

    localparam int RW = DENW + 1;
    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic            v0_reg;
    logic [NUMW-1:0] num0_reg;
    logic [DENW-1:0] den0_reg;
    cst_tag_t        tag0_reg;

    logic [VALUE_WIDTH:0]   v_reg;
    logic [RW-1:0]          rem_reg [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] nq_reg  [VALUE_WIDTH+1];
    logic [DENW-1:0]        dd_reg  [VALUE_WIDTH+1];
    cst_tag_t               tg_reg  [VALUE_WIDTH+1];
    logic                   ov_reg  [VALUE_WIDTH+1];

    logic [RW-1:0]          rem_next [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] nq_next  [VALUE_WIDTH+1];
    logic                   ov0_next;
    logic [NUMW-1:0]        high;

    logic                   res_valid_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    cst_tag_t               res_tag_reg;
    logic [VALUE_WIDTH-1:0] res_value_next;
    logic [VALUE_WIDTH-1:0] q;

    always_comb
    begin
        logic [RW-1:0] sh;
        logic          ge;
        sh = '0;
        ge = 1'b0;
        // upper part at or above the divisor means the quotient overflows
        high = num0_reg >> VALUE_WIDTH;
        ov0_next = high >= NUMW'(den0_reg);
        rem_next[0] = RW'(high);
        nq_next[0] = num0_reg[VALUE_WIDTH-1:0];
        for (int s = 1; s <= VALUE_WIDTH; s++)
        begin
            sh = {rem_reg[s-1][RW-2:0], nq_reg[s-1][VALUE_WIDTH-1]};
            ge = sh >= {1'b0, dd_reg[s-1]};
            rem_next[s] = ge ? (sh - {1'b0, dd_reg[s-1]}) : sh;
            nq_next[s] = {nq_reg[s-1][VALUE_WIDTH-2:0], ge};
        end
    end

    always_comb
    begin
        q = nq_reg[VALUE_WIDTH];
        if (tg_reg[VALUE_WIDTH].degen)
        begin
            res_value_next = '0;
        end
        else if (!tg_reg[VALUE_WIDTH].neg)
        begin
            res_value_next = (ov_reg[VALUE_WIDTH] || q > MAX_POS) ? MAX_POS : q;
        end
        else
        begin
            res_value_next = (ov_reg[VALUE_WIDTH] || q > MIN_NEG) ? MIN_NEG : (~q + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v_reg         <= {v_reg[VALUE_WIDTH-1:0], v0_reg};
            res_valid_reg <= v_reg[VALUE_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg  <= in_num;
            den0_reg  <= in_den;
            tag0_reg  <= in_tag;
            rem_reg[0] <= rem_next[0];
            nq_reg[0]  <= nq_next[0];
            dd_reg[0]  <= den0_reg;
            tg_reg[0]  <= tag0_reg;
            ov_reg[0]  <= ov0_next;
            for (int s = 1; s <= VALUE_WIDTH; s++)
            begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
                dd_reg[s]  <= dd_reg[s-1];
                tg_reg[s]  <= tg_reg[s-1];
                ov_reg[s]  <= ov_reg[s-1];
            end
            res_value_reg <= res_value_next;
            res_tag_reg   <= tg_reg[VALUE_WIDTH];
        end
    end

    assign out_valid = res_valid_reg;
    assign out_value = res_value_reg;
    assign out_tag   = res_tag_reg;

endmodule

/* rtl/cst_triangle_stiffness.sv */
// Top level: plane-stress triangle stiffness, 21 upper entries per element.
//
//  port      dir  beat                      payload
//  corners   in   one triangle              node0_x .. node2_y
//  entries   out  one stiffness entry       row_index col_index stiffness_value
//                                           degenerate last
//  cfg_*     in   one register write        cfg_index cfg_data
//
// A triangle is held in the entry sequencer while its 21 entries issue, one entry
// per cycle while entries does not stall, so the sustained triangle rate is set by
// the one entry result port; the next triangle loads as the last entry issues.
// Each entry passes eight arithmetic stages, then the bit-per-stage divider.
// A stall on entries freezes every stage at once; nothing is dropped or repeated.
// Reset clears valid bits and loads the register defaults.
`include "cst_triangle_stiffness_macros.svh"

module cst_triangle_stiffness #(
    parameter int COORD_WIDTH = cst_pkg::COORD_WIDTH_DEF,
    parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_data,
    cst_node_if.sink                        corners,
    cst_entry_if.source                     entries
);
    import cst_pkg::*;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int XBW   = COORD_WIDTH + DW;
    localparam int DETW  = XBW + 2;
    localparam int NW    = PW + 20;
    localparam int HL    = DETW / 2;
    localparam int HH    = DETW - HL;
    localparam int DENW  = DETW + CDEN_W;
    localparam int TEC   = TE_W / 2;
    localparam int PARTS = 4;
    localparam int NCH   = (NW + PARTS - 1) / PARTS;
    localparam int PPW   = TEC + NCH;
    localparam int RSW   = TEC + PARTS * NCH;
    localparam int NUMW  = TE_W + NW + KF_SHIFT;
    localparam int PPRW  = 2 * PR_W;

    // configuration
    logic [YM_W-1:0] ym_reg;
    logic [PR_W-1:0] pr_reg;
    logic [TH_W-1:0] th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ym_reg <= YM_RESET;
            pr_reg <= PR_RESET;
            th_reg <= TH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cst_reg_t'(cfg_index))
                REG_YOUNGS:  ym_reg <= cfg_data[YM_W-1:0];
                REG_POISSON: pr_reg <= cfg_data[PR_W-1:0];
                REG_THICK:   th_reg <= cfg_data[TH_W-1:0];
                default:     ;
            endcase
        end
    end

    // global advance: the output register is free or being drained
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || entries.ready;

    // entry sequencer
    logic                          seq_valid_reg;
    logic [2:0]                    seq_row_reg;
    logic [2:0]                    seq_col_reg;
    logic                          seq_last;
    logic signed [COORD_WIDTH-1:0] cx_reg [3];
    logic signed [COORD_WIDTH-1:0] cy_reg [3];

    assign seq_last = seq_row_reg == LAST_POS && seq_col_reg == LAST_POS;
    assign corners.ready = adv && (!seq_valid_reg || seq_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_row_reg   <= FIRST_POS;
            seq_col_reg   <= FIRST_POS;
        end
        else if (adv)
        begin
            if (seq_valid_reg && !seq_last)
            begin
                if (seq_col_reg == LAST_POS)
                begin
                    seq_row_reg <= seq_row_reg + 3'd1;
                    seq_col_reg <= seq_row_reg + 3'd1;
                end
                else
                begin
                    seq_col_reg <= seq_col_reg + 3'd1;
                end
            end
            else if (corners.valid)
            begin
                seq_valid_reg <= 1'b1;
                seq_row_reg   <= FIRST_POS;
                seq_col_reg   <= FIRST_POS;
            end
            else
            begin
                seq_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (corners.valid && corners.ready)
        begin
            cx_reg[0] <= corners.node0_x;
            cy_reg[0] <= corners.node0_y;
            cx_reg[1] <= corners.node1_x;
            cy_reg[1] <= corners.node1_y;
            cx_reg[2] <= corners.node2_x;
            cy_reg[2] <= corners.node2_y;
        end
    end

    // arithmetic pipeline
    logic [8:1]  v_reg;
    cst_tag_t    tag_reg  [1:8];
    cst_tag_t    tag_next [1:8];

    logic signed [COORD_WIDTH-1:0] x1_reg [3];
    logic signed [DW-1:0]          be_reg [3];
    logic signed [DW-1:0]          ga_reg [3];
    logic signed [DW-1:0]          be_next [3];
    logic signed [DW-1:0]          ga_next [3];

    logic signed [XBW-1:0] xb_reg [3];
    logic signed [XBW-1:0] xb_next [3];
    logic signed [PW-1:0]  st00_reg, st11_reg, st01_reg, st10_reg, st22_reg;
    logic signed [PW-1:0]  st00_next, st11_next, st01_next, st10_next, st22_next;
    logic [PPRW-1:0]       ppr_reg;
    logic [TE_W-1:0]       te2_reg;

    logic signed [DETW-1:0] det_reg;
    logic signed [SW-1:0]   a_reg, b_reg;
    logic signed [PW-1:0]   c_reg;
    logic [CDEN_W-1:0]      cden_reg;
    logic [TE_W-1:0]        te3_reg;

    logic [DETW-1:0]        absdet_reg;
    logic signed [SW-1:0]   a4_reg;
    logic signed [NW-1:0]   pb_reg, pc_reg;
    logic [CDEN_W-1:0]      cden4_reg;
    logic [TE_W-1:0]        te4_reg;
    logic [PR_W:0]          p2;
    logic [PR_W+1:0]        cc;

    logic [HL+CDEN_W-1:0]   dlo_reg;
    logic [HH+CDEN_W-1:0]   dhi_reg;
    logic signed [NW-1:0]   n_reg;
    logic [TE_W-1:0]        te5_reg;

    logic [DENW-1:0]        den6_reg;
    logic [NW-1:0]          absn_reg;
    logic [TE_W-1:0]        te6_reg;

    logic [PPW-1:0]         pp_reg  [2][PARTS];
    logic [PPW-1:0]         pp_next [2][PARTS];
    logic [PARTS*NCH-1:0]   absn_pad;
    logic [DENW-1:0]        den7_reg;

    logic [RSW-1:0]         rs_reg  [2];
    logic [RSW-1:0]         rs_next [2];
    logic [DENW-1:0]        den8_reg;
    logic [NUMW-1:0]        absnum;

    always_comb
    begin
        be_next[0] = DW'(cy_reg[1]) - DW'(cy_reg[2]);
        be_next[1] = DW'(cy_reg[2]) - DW'(cy_reg[0]);
        be_next[2] = DW'(cy_reg[0]) - DW'(cy_reg[1]);
        ga_next[0] = DW'(cx_reg[2]) - DW'(cx_reg[1]);
        ga_next[1] = DW'(cx_reg[0]) - DW'(cx_reg[2]);
        ga_next[2] = DW'(cx_reg[1]) - DW'(cx_reg[0]);
    end

    // strain columns of the two dofs of this entry
    always_comb
    begin
        logic signed [DW-1:0] s0, s1, s2, t0, t1, t2;
        logic [1:0]           nr, nc;
        nr = tag_reg[1].row[2:1];
        nc = tag_reg[1].col[2:1];
        s0 = tag_reg[1].row[0] ? '0 : be_reg[nr];
        s1 = tag_reg[1].row[0] ? ga_reg[nr] : '0;
        s2 = tag_reg[1].row[0] ? be_reg[nr] : ga_reg[nr];
        t0 = tag_reg[1].col[0] ? '0 : be_reg[nc];
        t1 = tag_reg[1].col[0] ? ga_reg[nc] : '0;
        t2 = tag_reg[1].col[0] ? be_reg[nc] : ga_reg[nc];
        st00_next = PW'(s0) * PW'(t0);
        st11_next = PW'(s1) * PW'(t1);
        st01_next = PW'(s0) * PW'(t1);
        st10_next = PW'(s1) * PW'(t0);
        st22_next = PW'(s2) * PW'(t2);
        for (int i = 0; i < 3; i++)
        begin
            xb_next[i] = XBW'(x1_reg[i]) * XBW'(be_reg[i]);
        end
    end

    assign p2 = {pr_reg, 1'b0};
    assign cc = (PR_W+2)'(17'd65536 - 17'(pr_reg));
    assign absn_pad = (PARTS*NCH)'(absn_reg);

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < PARTS; i++)
            begin
                pp_next[j][i] = PPW'(te6_reg[j*TEC +: TEC]) * PPW'(absn_pad[i*NCH +: NCH]);
            end
        end
        for (int j = 0; j < 2; j++)
        begin
            rs_next[j] = '0;
            for (int i = 0; i < PARTS; i++)
            begin
                rs_next[j] = rs_next[j] + (RSW'(pp_reg[j][i]) << (i * NCH));
            end
        end
    end

    assign absnum = (NUMW'(rs_reg[0]) + (NUMW'(rs_reg[1]) << TEC)) << KF_SHIFT;

    // tag_next[s] is what stage s loads
    always_comb
    begin
        tag_next[1] = '{row: seq_row_reg, col: seq_col_reg, last: seq_last,
                        degen: 1'b0, neg: 1'b0};
        for (int s = 2; s < 9; s++)
        begin
            tag_next[s] = tag_reg[s-1];
        end
        tag_next[4].degen = det_reg == '0;
        tag_next[6].neg   = n_reg[NW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[7:1], seq_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 1; s < 9; s++)
            begin
                tag_reg[s] <= tag_next[s];
            end
            // stage 1: differences
            for (int i = 0; i < 3; i++)
            begin
                x1_reg[i] <= cx_reg[i];
                be_reg[i] <= be_next[i];
                ga_reg[i] <= ga_next[i];
            end
            // stage 2: products
            for (int i = 0; i < 3; i++)
            begin
                xb_reg[i] <= xb_next[i];
            end
            st00_reg <= st00_next;
            st11_reg <= st11_next;
            st01_reg <= st01_next;
            st10_reg <= st10_next;
            st22_reg <= st22_next;
            ppr_reg  <= PPRW'(pr_reg) * PPRW'(pr_reg);
            te2_reg  <= TE_W'(th_reg) * TE_W'(ym_reg);
            // stage 3: sums
            det_reg  <= DETW'(xb_reg[0]) + DETW'(xb_reg[1]) + DETW'(xb_reg[2]);
            a_reg    <= SW'(st00_reg) + SW'(st11_reg);
            b_reg    <= SW'(st01_reg) + SW'(st10_reg);
            c_reg    <= st22_reg;
            cden_reg <= 33'h1_0000_0000 - CDEN_W'(ppr_reg);
            te3_reg  <= te2_reg;
            // stage 4: magnitude of det, Poisson weighting
            absdet_reg <= DETW'(det_reg[DETW-1] ? -det_reg : det_reg);
            a4_reg     <= a_reg;
            pb_reg     <= NW'($signed({1'b0, p2})) * NW'(b_reg);
            pc_reg     <= NW'($signed({1'b0, cc})) * NW'(c_reg);
            cden4_reg  <= cden_reg;
            te4_reg    <= te3_reg;
            // stage 5: denominator halves, numerator sum
            dlo_reg <= (HL+CDEN_W)'(absdet_reg[HL-1:0]) * (HL+CDEN_W)'(cden4_reg);
            dhi_reg <= (HH+CDEN_W)'(absdet_reg[DETW-1:HL]) * (HH+CDEN_W)'(cden4_reg);
            n_reg   <= (NW'(a4_reg) <<< 17) + pb_reg + pc_reg;
            te5_reg <= te4_reg;
            // stage 6
            den6_reg <= DENW'(dlo_reg) + (DENW'(dhi_reg) << HL);
            absn_reg <= NW'(n_reg[NW-1] ? -n_reg : n_reg);
            te6_reg  <= te5_reg;
            // stage 7: partial products of t*E by |N|
            pp_reg   <= pp_next;
            den7_reg <= den6_reg;
            // stage 8
            rs_reg   <= rs_next;
            den8_reg <= den7_reg;
        end
    end

    // division and saturation
    logic                   dv;
    logic [VALUE_WIDTH-1:0] dvalue;
    cst_tag_t               dtag;

    cst_div #(
        .NUMW        (NUMW),
        .DENW        (DENW),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_reg[8]),
        .in_num    (absnum),
        .in_den    (den8_reg),
        .in_tag    (tag_reg[8]),
        .out_valid (dv),
        .out_value (dvalue),
        .out_tag   (dtag)
    );

    // output register
    logic [2:0]             out_row_reg;
    logic [2:0]             out_col_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_degen_reg;
    logic                   out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg   <= dtag.row;
            out_col_reg   <= dtag.col;
            out_value_reg <= dvalue;
            out_degen_reg <= dtag.degen;
            out_last_reg  <= dtag.last;
        end
    end

    assign entries.valid           = out_valid_reg;
    assign entries.row_index       = out_row_reg;
    assign entries.col_index       = out_col_reg;
    assign entries.stiffness_value = out_value_reg;
    assign entries.degenerate      = out_degen_reg;
    assign entries.last            = out_last_reg;

    `CST_ASSERT_NEXT(a_load, clk, rst_n, corners.valid && corners.ready, seq_valid_reg && seq_row_reg == FIRST_POS && seq_col_reg == FIRST_POS)
    `CST_ASSERT_IMP(a_busy, clk, rst_n, seq_valid_reg && !seq_last, !corners.ready)
    `CST_ASSERT_IMP(a_last, clk, rst_n, out_valid_reg && out_last_reg, out_row_reg == LAST_POS && out_col_reg == LAST_POS)
    `CST_ASSERT_IMP(a_degen, clk, rst_n, out_valid_reg && out_degen_reg, out_value_reg == '0)
    `CST_ASSERT_IMP(a_upper, clk, rst_n, out_valid_reg, out_col_reg >= out_row_reg)

endmodule
